// ----- hdl/mic_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg
// Shared types and constants of the multiset intersection counter: operation
// codes, parameter defaults and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mic_pkg;

    // operation codes of a request
    localparam logic [1:0] OP_COUNT = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // parameter defaults
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_BITS_DEF    = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture an accepted request
        logic scan;      // step the key search
        logic update;    // write the table and form the result
        logic out_load;  // move the result into the output register
    } mic_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_done; // search has found the key or run past the last entry
    } mic_status_t;

endpackage

// ----- hdl/mic_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_ctrl
// Controller: sequences capture, key search, table update and result hand-off
// for one request at a time, and owns the handshake of both channels.
// ----------------------------------------------------------------------------
module mic_ctrl
    import mic_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    output logic        m_valid,
    input  logic        m_ready,
    output mic_cmd_t    cmd,
    input  mic_status_t status
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       s_fire;
    logic       out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd.load = 1'b1;
                    if (s_operation == OP_COUNT || s_operation == OP_PROBE) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- hdl/mic_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_datapath
// Datapath: key and count memory, fill count, pipelined key search, update
// arithmetic and the result registers.
// ----------------------------------------------------------------------------
module mic_datapath
    import mic_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_item_value,
    input  mic_cmd_t           cmd,
    output mic_status_t        status,
    output logic               m_hit,
    output logic signed [31:0] m_match_value,
    output logic               m_table_full
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
    localparam int WORD_W = 32 + COUNT_BITS;
    localparam logic [FILL_W-1:0]     FILL_MAX  = FILL_W'(TABLE_ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // table memory, key in the upper bits and count in the lower
    logic [WORD_W-1:0] mem [TABLE_ENTRIES];
    logic [WORD_W-1:0] rd_data_reg;

    // used entries always form a prefix, so a fill count stands in for valid bits
    logic [FILL_W-1:0]     fill_reg;
    logic [1:0]            op_reg;
    logic [31:0]           value_reg;
    logic [FILL_W-1:0]     rd_idx_reg;
    logic                  pend_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_idx_reg;
    logic [COUNT_BITS-1:0] found_cnt_reg;

    logic                  res_hit_reg;
    logic [31:0]           res_match_reg;
    logic                  res_full_reg;
    logic                  m_hit_reg;
    logic [31:0]           m_match_reg;
    logic                  m_full_reg;

    logic                  key_match;
    logic                  rd_issue;
    logic                  scan_done;
    logic [31:0]           rd_key;
    logic [COUNT_BITS-1:0] rd_cnt;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic                  fill_inc;
    logic                  upd_hit;
    logic                  upd_full;

    assign rd_key = rd_data_reg[WORD_W-1:COUNT_BITS];
    assign rd_cnt = rd_data_reg[COUNT_BITS-1:0];

    // search: one read issued a cycle, compare on the registered read data
    assign key_match = pend_reg && (rd_key == value_reg);
    assign rd_issue  = cmd.scan && !key_match && (rd_idx_reg != fill_reg);
    assign scan_done = key_match || (!pend_reg && (rd_idx_reg == fill_reg));
    assign status.scan_done = scan_done;

    // update decision
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = found_idx_reg;
        wr_data  = {value_reg, found_cnt_reg};
        fill_inc = 1'b0;
        upd_hit  = 1'b0;
        upd_full = 1'b0;
        case (op_reg)
            OP_COUNT: begin
                if (found_reg) begin
                    if (found_cnt_reg != COUNT_MAX) begin
                        wr_en   = 1'b1;
                        wr_data = {value_reg, found_cnt_reg + COUNT_ONE};
                    end
                end else if (fill_reg != FILL_MAX) begin
                    wr_en    = 1'b1;
                    wr_addr  = fill_reg[IDX_W-1:0];
                    wr_data  = {value_reg, COUNT_ONE};
                    fill_inc = 1'b1;
                end else begin
                    upd_full = 1'b1;
                end
            end
            OP_PROBE: begin
                if (found_reg && (|found_cnt_reg)) begin
                    wr_en   = 1'b1;
                    wr_data = {value_reg, found_cnt_reg - COUNT_ONE};
                    upd_hit = 1'b1;
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (cmd.update && wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                pend_reg <= 1'b0;
                if (s_operation == OP_CLEAR) begin
                    fill_reg <= '0;
                end
            end else if (cmd.scan) begin
                pend_reg <= rd_issue;
            end else if (cmd.update && fill_inc) begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
        end
    end

    // request and search payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg        <= s_operation;
            value_reg     <= s_item_value;
            rd_idx_reg    <= '0;
            res_hit_reg   <= 1'b0;
            res_match_reg <= '0;
            res_full_reg  <= 1'b0;
        end
        if (rd_issue) begin
            rd_idx_reg   <= rd_idx_reg + FILL_W'(1);
            pend_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
        if (cmd.scan && scan_done) begin
            found_reg     <= key_match;
            found_idx_reg <= pend_idx_reg;
            found_cnt_reg <= rd_cnt;
        end
        if (cmd.update) begin
            res_hit_reg   <= upd_hit;
            res_match_reg <= upd_hit ? value_reg : 32'd0;
            res_full_reg  <= upd_full;
        end
        if (cmd.out_load) begin
            m_hit_reg   <= res_hit_reg;
            m_match_reg <= res_match_reg;
            m_full_reg  <= res_full_reg;
        end
    end

    assign m_hit         = m_hit_reg;
    assign m_match_value = m_match_reg;
    assign m_table_full  = m_full_reg;

endmodule

// ----- hdl/multiset_intersection_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_intersection_counter
// Keyed count table giving the multiset intersection of two value streams.
//
// Requests arrive on the s_ channel (valid/ready): operation 0 counts
// s_item_value, 1 probes it, 2 clears the table, 3 is ignored. Every request
// gives exactly one result on the m_ channel: m_hit with m_match_value on a
// successful probe, m_table_full when a count found no free entry.
// One request is handled at a time. A count or probe searches the used
// entries in order, one memory read a cycle, until it finds the key or
// has read every entry in use (at most TABLE_ENTRIES); clear and unused
// codes skip the search. The next request is accepted at the edge where
// the previous result can first be taken.
// The search length is set by the single read port of the table memory.
// Reset empties the table (fill count to zero) with no clearing pass; the
// block is ready in the first cycle after reset.
// The result sits in an output register; if the receiver stalls, the next
// request is still accepted and processed, and waits before hand-off until
// the output register is free.
// ----------------------------------------------------------------------------
module multiset_intersection_counter
    import mic_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic signed [31:0] s_item_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic signed [31:0] m_match_value,
    output logic               m_table_full
);

    mic_cmd_t    cmd;
    mic_status_t status;

    // sequencing and handshake
    mic_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

    // table, search and results
    mic_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_operation   (s_operation),
        .s_item_value  (s_item_value),
        .cmd           (cmd),
        .status        (status),
        .m_hit         (m_hit),
        .m_match_value (m_match_value),
        .m_table_full  (m_table_full)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiset intersection counter. Count, probe,
// clear and unused-code requests go in through the s_ channel. A model of the
// count table, kept inside the bench, works out the result that each accepted
// request should give. Each result taken from the m_ channel is compared field
// by field with the oldest outstanding prediction. Directed cases cover value
// extremes, exhausted entries, a full table and repeated counts on one key.
// Random rounds of counts and probes follow, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
    import mic_pkg::*;

    localparam int          TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int          COUNT_BITS    = COUNT_BITS_DEF;
    localparam logic [1:0]  OP_UNUSED     = 2'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam longint      LIMIT_CYCLES  = 6_000_000;

    typedef struct packed {
        logic        hit;
        logic [31:0] match_value;
        logic        table_full;
    } mic_result_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic [1:0]         s_operation   = OP_COUNT;
    logic signed [31:0] s_item_value  = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_hit;
    logic signed [31:0] m_match_value;
    logic               m_table_full;

    // bench copy of the count table
    logic [31:0]           tally_key   [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] tally_count [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] tally_used = '0;

    mic_result_t pending_results[$];
    mic_result_t oldest;
    bit          idling_on    = 1'b1;
    int          n_errors     = 0;
    int          n_requests   = 0;
    int          n_results    = 0;
    int          n_hits       = 0;
    int          n_full       = 0;
    longint      cycle_count  = 0;

    multiset_intersection_counter #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_item_value  (s_item_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_match_value (m_match_value),
        .m_table_full  (m_table_full)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** multiset_intersection_counter: FAILED **");
            $finish;
        end
    end

    // apply one request to the bench table and return the result it gives
    function automatic mic_result_t apply_request(input logic [1:0] op,
                                                  input logic [31:0] value);
        mic_result_t r;
        int          slot;
        r    = '0;
        slot = -1;
        if (op == OP_COUNT || op == OP_PROBE) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot < 0 && tally_used[i] && tally_key[i] == value)
                    slot = i;
            end
        end
        case (op)
            OP_COUNT: begin
                if (slot >= 0) begin
                    if (tally_count[slot] != COUNT_MAX)
                        tally_count[slot]++;
                end else begin
                    // lowest free slot takes the new key
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (slot < 0 && !tally_used[i])
                            slot = i;
                    end
                    if (slot >= 0) begin
                        tally_key[slot]   = value;
                        tally_count[slot] = COUNT_BITS'(1);
                        tally_used[slot]  = 1'b1;
                    end else begin
                        r.table_full = 1'b1;
                    end
                end
            end
            OP_PROBE: begin
                if (slot >= 0 && tally_count[slot] != '0) begin
                    tally_count[slot]--;
                    r.hit         = 1'b1;
                    r.match_value = value;
                end
            end
            OP_CLEAR: tally_used = '0;
            default: ;
        endcase
        return r;
    endfunction

    // send one request, predict its result once accepted
    task automatic send_request(input logic [1:0] op, input logic [31:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_item_value <= value;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pending_results.insert(pending_results.size(), apply_request(op, value));
        n_requests++;
    endtask

    // result receiver with random stall bursts
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endtask

    // result checker: signals are stable at the falling edge
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                oldest = pending_results.pop_front();
                check_field("hit", 32'(oldest.hit), 32'(m_hit));
                check_field("match_value", oldest.match_value, m_match_value);
                check_field("table_full", 32'(oldest.table_full), 32'(m_table_full));
                n_results++;
                if (oldest.hit)
                    n_hits++;
                if (oldest.table_full)
                    n_full++;
            end
        end
    end

    // value extremes, exhausted entries, unused code, clear
    task automatic test_directed();
        send_request(OP_PROBE, 32'd5);
        send_request(OP_CLEAR, $urandom);
        send_request(OP_COUNT, 32'h8000_0000);
        send_request(OP_COUNT, 32'h7fff_ffff);
        send_request(OP_COUNT, 32'h0000_0000);
        send_request(OP_COUNT, 32'hffff_ffff);
        send_request(OP_COUNT, 32'h7fff_ffff);
        send_request(OP_PROBE, 32'h8000_0000);
        send_request(OP_PROBE, 32'h8000_0000);
        send_request(OP_COUNT, 32'h8000_0000);
        send_request(OP_PROBE, 32'h7fff_ffff);
        send_request(OP_PROBE, 32'h7fff_ffff);
        send_request(OP_PROBE, 32'h7fff_ffff);
        send_request(OP_UNUSED, 32'hffff_ffff);
        send_request(OP_PROBE, 32'hffff_ffff);
        send_request(OP_PROBE, 32'h5555_5555);
        send_request(OP_PROBE, 32'haaaa_aaaa);
        send_request(OP_COUNT, 32'haaaa_aaaa);
        send_request(OP_PROBE, 32'haaaa_aaaa);
        send_request(OP_CLEAR, 32'h7fff_ffff);
        send_request(OP_PROBE, 32'h0000_0000);
        send_request(OP_COUNT, 32'h0000_0000);
        send_request(OP_PROBE, 32'h0000_0000);
        send_request(OP_CLEAR, 32'h0);
    endtask

    // fill every entry, then try a new key
    task automatic test_table_full();
        logic [31:0] keys[$];
        logic [31:0] candidate;
        logic [31:0] outsider;
        bit          seen;
        send_request(OP_CLEAR, $urandom);
        while (keys.size() < TABLE_ENTRIES + 1) begin
            candidate = $urandom;
            seen      = 1'b0;
            foreach (keys[k])
                if (keys[k] == candidate)
                    seen = 1'b1;
            if (!seen)
                keys.insert(keys.size(), candidate);
        end
        outsider = keys.pop_back();
        foreach (keys[i])
            send_request(OP_COUNT, keys[i]);
        send_request(OP_COUNT, outsider);
        send_request(OP_COUNT, keys[3]);
        send_request(OP_PROBE, outsider);
        foreach (keys[i])
            send_request(OP_PROBE, keys[i]);
        send_request(OP_PROBE, keys[3]);
        send_request(OP_PROBE, keys[3]);
        // exhausted entries still hold their slots
        send_request(OP_COUNT, outsider);
        send_request(OP_CLEAR, $urandom);
        send_request(OP_COUNT, outsider);
        send_request(OP_PROBE, outsider);
    endtask

    // rounds of counts then probes over a shared pool of values
    task automatic test_random_rounds(input int n_items, input bit allow_idle);
        logic [31:0] pool[$];
        int          pool_size;
        int          target;
        int          roll;
        target = n_requests + n_items;
        while (n_requests < target) begin
            idling_on = allow_idle && ($urandom_range(0, 4) != 0);
            pool.delete();
            pool_size = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 70)
                                                     : $urandom_range(1, 8);
            repeat (pool_size) begin
                roll = $urandom_range(0, 9);
                pool.insert(pool.size(),
                            roll == 0 ? 32'h8000_0000 :
                            roll == 1 ? 32'h7fff_ffff :
                            roll == 2 ? 32'($urandom_range(0, 3)) : $urandom);
            end
            if ($urandom_range(0, 3) != 0)
                send_request(OP_CLEAR, $urandom);
            repeat ($urandom_range(1, 3 * pool_size)) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send_request(OP_UNUSED, $urandom);
                else if (roll == 1)
                    send_request(OP_PROBE, pool[$urandom_range(0, pool_size - 1)]);
                else
                    send_request(OP_COUNT, pool[$urandom_range(0, pool_size - 1)]);
            end
            repeat ($urandom_range(1, 3 * pool_size)) begin
                roll = $urandom_range(0, 19);
                if (roll == 0)
                    send_request(OP_UNUSED, $urandom);
                else if (roll < 3)
                    send_request(OP_PROBE, $urandom);
                else if (roll == 3)
                    send_request(OP_COUNT, pool[$urandom_range(0, pool_size - 1)]);
                else
                    send_request(OP_PROBE, pool[$urandom_range(0, pool_size - 1)]);
            end
        end
    endtask

    // repeated counts on one key, past the ceiling when the count is narrow
    task automatic test_count_saturation();
        logic [31:0] key;
        int          n_counts;
        key      = $urandom;
        n_counts = (COUNT_BITS <= 5) ? (1 << COUNT_BITS) + 1 : 40;
        send_request(OP_CLEAR, $urandom);
        repeat (n_counts) send_request(OP_COUNT, key);
        repeat (3) send_request(OP_PROBE, key);
        repeat (2) send_request(OP_COUNT, key);
        send_request(OP_PROBE, key);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_table_full();
        test_random_rounds(350, 1'b1);
        // final stretch runs with no idling on either side
        idling_on = 1'b0;
        test_random_rounds(120, 1'b0);
        test_count_saturation();
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TABLE_ENTRIES + 10) @(posedge aclk);

        $display("covered %0d requests and %0d results: %0d probe hits, %0d full drops",
                 n_requests, n_results, n_hits, n_full);
        $display("including value extremes, a full table and repeated counts on one key");
        if (n_errors == 0) begin
            $display("** multiset_intersection_counter: PASSED **");
        end else begin
            $display("** multiset_intersection_counter: FAILED **");
        end
        $finish;
    end

endmodule
